// File: rtl/core/lrgd_pkg.sv
package lrgd_pkg;

   localparam int DATA_W      = 32;
   localparam int ACC_W       = 64;
   localparam int PROD_W      = 66;
   localparam int WIDE_W      = 96;
   localparam int LR_W        = 32;
   localparam int ITER_W      = 16;
   localparam int COST_W      = 48;
   localparam int COUNT_OUT_W = 7;
   localparam int CSR_INDEX_W = 2;

   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_LEARNING_RATE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_INTERCEPT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_SLOPE     = 2'd3;

   localparam logic [LR_W-1:0]   LEARNING_RATE_RESET   = 32'd42950;
   localparam logic [ITER_W-1:0] ITERATION_COUNT_RESET = 16'd20;

   localparam logic [DATA_W-1:0] INT32_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] INT32_MIN = 32'h8000_0000;
   localparam logic [ACC_W-1:0]  INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0]  INT64_MIN = 64'h8000_0000_0000_0000;
   localparam logic [ACC_W-1:0]  UINT64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [COST_W-1:0] COST_MAX = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_DIV,
      ST_INIT,
      ST_PASS_START,
      ST_READ,
      ST_MUL_P,
      ST_RES,
      ST_MUL_HC,
      ST_ACC_I,
      ST_MUL_HX,
      ST_HX,
      ST_MUL_LO,
      ST_LO,
      ST_MUL_HI,
      ST_HI,
      ST_ACC_S,
      ST_PASS_END,
      ST_COST_START,
      ST_MUL_SQ,
      ST_ACC_C,
      ST_COST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              clip;
      logic [DATA_W-1:0] value;
   } sat32_type;

   typedef struct packed {
      logic             clip;
      logic [ACC_W-1:0] value;
   } sat64_type;

endpackage

// File: rtl/core/linear_regression_gradient_descent_core.sv
// Batch gradient-descent line fit, y = intercept + slope * x, all Q16.16 by default.
// req_*: one (x, y) sample per transaction, one transaction per cycle while loading.
//   Samples beyond MAX_SAMPLES are dropped. The transaction with req_last_sample set
//   ends the set and starts training; req_ready stays low until the result is registered.
// rsp_*: one transaction per set: fitted intercept, slope, half mean squared error,
//   sample count and a flag for any clipped residual, parameter, sum or cost.
// csr_*: register writes (index 0 learning rate, 1 pass count, 2 initial intercept,
//   3 initial slope); csr_ready is always high. Write only while no set is training.
// A single 33x33 multiplier serves every product, and a bit-serial divider forms
//   both learning_rate / n and the final cost division.
// Reset returns the block to loading with an empty set and the register defaults.
// A result not taken by the receiver holds in the output register; loading of the
// next set proceeds meanwhile, and the next result waits until the slot is free.
module linear_regression_gradient_descent_core #(
   parameter int MAX_SAMPLES = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [lrgd_pkg::DATA_W-1:0]        req_sample_x,
   input  logic signed [lrgd_pkg::DATA_W-1:0]        req_sample_y,
   input  logic                                      req_last_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [lrgd_pkg::DATA_W-1:0]        rsp_fitted_intercept,
   output logic signed [lrgd_pkg::DATA_W-1:0]        rsp_fitted_slope,
   output logic        [lrgd_pkg::COST_W-1:0]        rsp_final_cost,
   output logic        [lrgd_pkg::COUNT_OUT_W-1:0]   rsp_sample_count,
   output logic                                      rsp_saturated,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic        [lrgd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic        [lrgd_pkg::DATA_W-1:0]        csr_data
);
   import lrgd_pkg::*;

   localparam int AW       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CW       = $clog2(MAX_SAMPLES + 1);
   localparam int SLOPE_SH = 2 * FRAC_BITS;
   localparam int SUM_SH   = LR_W - FRAC_BITS;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SAMPLES);

   function automatic sat32_type clip32(input logic signed [PROD_W-1:0] v);
      sat32_type r;
      if (v[PROD_W-1:DATA_W-1] == '0 || v[PROD_W-1:DATA_W-1] == '1) begin
         r.clip  = 1'b0;
         r.value = v[DATA_W-1:0];
      end else begin
         r.clip  = 1'b1;
         r.value = v[PROD_W-1] ? INT32_MIN : INT32_MAX;
      end
      return r;
   endfunction

   function automatic sat64_type clip64(input logic signed [WIDE_W-1:0] v);
      sat64_type r;
      if (v[WIDE_W-1:ACC_W-1] == '0 || v[WIDE_W-1:ACC_W-1] == '1) begin
         r.clip  = 1'b0;
         r.value = v[ACC_W-1:0];
      end else begin
         r.clip  = 1'b1;
         r.value = v[WIDE_W-1] ? INT64_MIN : INT64_MAX;
      end
      return r;
   endfunction

   function automatic sat64_type sat_add64(input logic [ACC_W-1:0] a,
                                           input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      sat64_type      r;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         r.clip  = 1'b1;
         r.value = s[ACC_W] ? INT64_MIN : INT64_MAX;
      end else begin
         r.clip  = 1'b0;
         r.value = s[ACC_W-1:0];
      end
      return r;
   endfunction

   // control
   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LR_W-1:0]       lr_ff, lr_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic signed [DATA_W-1:0] init_t0_ff, init_t0_in, init_t1_ff, init_t1_in;

   // datapath
   logic [AW-1:0]            idx_ff, idx_in;
   logic [ITER_W-1:0]        pass_ff, pass_in;
   logic                     cost_phase_ff, cost_phase_in;
   logic signed [DATA_W-1:0] t0_ff, t0_in, t1_ff, t1_in, h_ff, h_in;
   logic [LR_W-1:0]          c_ff, c_in;
   logic signed [ACC_W-1:0]  isum_ff, isum_in, ssum_ff, ssum_in, hx_ff, hx_in;
   logic [ACC_W-1:0]         csum_ff, csum_in, lo_ff, lo_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [WIDE_W-1:0] full_ff, full_in;
   logic [DIV_W-1:0]         div_ff, div_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]     divcnt_ff, divcnt_in;
   logic                     clip_ff, clip_in;
   logic signed [DATA_W-1:0] rsp_t0_ff, rsp_t0_in, rsp_t1_ff, rsp_t1_in;
   logic [COST_W-1:0]        rsp_cost_ff, rsp_cost_in;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   logic [2*DATA_W-1:0] mem [MAX_SAMPLES];
   logic [2*DATA_W-1:0] rd_ff;
   logic                mem_we;

   logic signed [DATA_W:0] mul_a, mul_b;
   logic signed [DATA_W-1:0] rd_x, rd_y;
   logic req_fire, rsp_fire, csr_fire, last_idx, slot_free, cost_big;
   logic [ITER_W-1:0] pass_next;
   logic signed [ACC_W-1:0]  p_shift;
   logic signed [PROD_W-1:0] res_raw, iterm_wide, t0_raw, t1_raw;
   logic signed [WIDE_W-1:0] s_shift, full_sum;
   logic [ACC_W-1:0]  sq;
   logic [ACC_W:0]    csum_add;
   logic [CW:0]       rem_shift, rem_diff;
   logic              div_ge;
   sat32_type         res_sat, t0_sat, t1_sat;
   sat64_type         iacc, sterm, sacc;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_idx  = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign pass_next = pass_ff + ITER_W'(1);

   assign rd_x = rd_ff[2*DATA_W-1:DATA_W];
   assign rd_y = rd_ff[DATA_W-1:0];

   // residual h = t0 + floor(t1*x / 2^F) - y
   assign p_shift = $signed(prod_ff[ACC_W-1:0]) >>> FRAC_BITS;
   assign res_raw = PROD_W'(t0_ff) + PROD_W'(p_shift) - PROD_W'(rd_y);
   assign res_sat = clip32(res_raw);

   assign iterm_wide = prod_ff >>> FRAC_BITS;
   assign iacc       = sat_add64(isum_ff, iterm_wide[ACC_W-1:0]);

   // recombine the two partial products of (h*x) * c
   assign full_sum = $signed({prod_ff[ACC_W-1:0], {DATA_W{1'b0}}})
                   + $signed({{DATA_W{1'b0}}, lo_ff});
   assign s_shift  = full_ff >>> SLOPE_SH;
   assign sterm    = clip64(s_shift);
   assign sacc     = sat_add64(ssum_ff, sterm.value);

   assign t0_raw = PROD_W'(t0_ff) - PROD_W'(isum_ff >>> SUM_SH);
   assign t1_raw = PROD_W'(t1_ff) - PROD_W'(ssum_ff >>> SUM_SH);
   assign t0_sat = clip32(t0_raw);
   assign t1_sat = clip32(t1_raw);

   assign sq       = prod_ff[ACC_W-1:0] >> FRAC_BITS;
   assign csum_add = {1'b0, csum_ff} + {1'b0, sq};

   // restoring divider, one quotient bit per cycle
   assign rem_shift = {rem_ff, div_ff[DIV_W-1]};
   assign div_ge    = rem_shift >= {1'b0, count_ff};
   assign rem_diff  = rem_shift - {1'b0, count_ff};

   assign cost_big = div_ff[DIV_W-1:COST_W] != '0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_last_sample) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (divcnt_ff == DIV_LAST) state_in = cost_phase_ff ? ST_DONE : ST_INIT;
         end
         ST_INIT:       state_in = (iter_ff == '0) ? ST_COST_START : ST_PASS_START;
         ST_PASS_START: state_in = ST_READ;
         ST_READ:       state_in = ST_MUL_P;
         ST_MUL_P:      state_in = ST_RES;
         ST_RES:        state_in = cost_phase_ff ? ST_MUL_SQ : ST_MUL_HC;
         ST_MUL_HC:     state_in = ST_ACC_I;
         ST_ACC_I:      state_in = ST_MUL_HX;
         ST_MUL_HX:     state_in = ST_HX;
         ST_HX:         state_in = ST_MUL_LO;
         ST_MUL_LO:     state_in = ST_LO;
         ST_LO:         state_in = ST_MUL_HI;
         ST_MUL_HI:     state_in = ST_HI;
         ST_HI:         state_in = ST_ACC_S;
         ST_ACC_S:      state_in = last_idx ? ST_PASS_END : ST_READ;
         ST_PASS_END:   state_in = (pass_next == iter_ff) ? ST_COST_START : ST_PASS_START;
         ST_COST_START: state_in = ST_READ;
         ST_MUL_SQ:     state_in = ST_ACC_C;
         ST_ACC_C:      state_in = last_idx ? ST_COST_DIV : ST_READ;
         ST_COST_DIV:   state_in = ST_DIV;
         ST_DONE: begin
            if (slot_free) state_in = ST_LOAD;
         end
         default:       state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      mem_we        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      cost_phase_in = cost_phase_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      h_in          = h_ff;
      c_in          = c_ff;
      isum_in       = isum_ff;
      ssum_in       = ssum_ff;
      hx_in         = hx_ff;
      csum_in       = csum_ff;
      lo_in         = lo_ff;
      full_in       = full_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      divcnt_in     = divcnt_ff;
      clip_in       = clip_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_t0_in     = rsp_t0_ff;
      rsp_t1_in     = rsp_t1_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_sat_in    = rsp_sat_ff;
      lr_in         = lr_ff;
      iter_in       = iter_ff;
      init_t0_in    = init_t0_ff;
      init_t1_in    = init_t1_ff;

      if (csr_fire) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:     lr_in      = csr_data;
            CSR_ITERATION_COUNT:   iter_in    = csr_data[ITER_W-1:0];
            CSR_INITIAL_INTERCEPT: init_t0_in = csr_data;
            CSR_INITIAL_SLOPE:     init_t1_in = csr_data;
         endcase
      end

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_fire) begin
               // drop the sample once the store is full
               if (count_ff < MAX_COUNT) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end
               if (req_last_sample) begin
                  div_in        = DIV_W'(lr_ff);
                  rem_in        = '0;
                  divcnt_in     = '0;
                  cost_phase_in = 1'b0;
               end
            end
         end
         ST_DIV: begin
            rem_in    = div_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
            div_in    = {div_ff[DIV_W-2:0], div_ge};
            divcnt_in = divcnt_ff + DIV_CNT_W'(1);
         end
         ST_INIT: begin
            c_in    = div_ff[LR_W-1:0];
            t0_in   = init_t0_ff;
            t1_in   = init_t1_ff;
            clip_in = 1'b0;
            pass_in = '0;
         end
         ST_PASS_START: begin
            isum_in = '0;
            ssum_in = '0;
            idx_in  = '0;
         end
         ST_READ: begin
         end
         ST_MUL_P: begin
            mul_a = (DATA_W+1)'(t1_ff);
            mul_b = (DATA_W+1)'(rd_x);
         end
         ST_RES: begin
            h_in = res_sat.value;
            if (res_sat.clip) clip_in = 1'b1;
         end
         ST_MUL_HC: begin
            mul_a = (DATA_W+1)'(h_ff);
            mul_b = $signed({1'b0, c_ff});
         end
         ST_ACC_I: begin
            isum_in = iacc.value;
            if (iacc.clip) clip_in = 1'b1;
         end
         ST_MUL_HX: begin
            mul_a = (DATA_W+1)'(h_ff);
            mul_b = (DATA_W+1)'(rd_x);
         end
         ST_HX: begin
            hx_in = prod_ff[ACC_W-1:0];
         end
         ST_MUL_LO: begin
            mul_a = $signed({1'b0, hx_ff[DATA_W-1:0]});
            mul_b = $signed({1'b0, c_ff});
         end
         ST_LO: begin
            lo_in = prod_ff[ACC_W-1:0];
         end
         ST_MUL_HI: begin
            mul_a = (DATA_W+1)'($signed(hx_ff[ACC_W-1:DATA_W]));
            mul_b = $signed({1'b0, c_ff});
         end
         ST_HI: begin
            full_in = full_sum;
         end
         ST_ACC_S: begin
            ssum_in = sacc.value;
            if (sterm.clip || sacc.clip) clip_in = 1'b1;
            idx_in = idx_ff + AW'(1);
         end
         ST_PASS_END: begin
            t0_in   = t0_sat.value;
            t1_in   = t1_sat.value;
            if (t0_sat.clip || t1_sat.clip) clip_in = 1'b1;
            pass_in = pass_next;
         end
         ST_COST_START: begin
            csum_in       = '0;
            idx_in        = '0;
            cost_phase_in = 1'b1;
         end
         ST_MUL_SQ: begin
            mul_a = (DATA_W+1)'(h_ff);
            mul_b = (DATA_W+1)'(h_ff);
         end
         ST_ACC_C: begin
            if (csum_add[ACC_W]) begin
               csum_in = UINT64_MAX;
               clip_in = 1'b1;
            end else begin
               csum_in = csum_add[ACC_W-1:0];
            end
            idx_in = idx_ff + AW'(1);
         end
         ST_COST_DIV: begin
            // floor(sum / 2n) = floor(floor(sum / 2) / n)
            div_in    = {1'b0, csum_ff[ACC_W-1:1]};
            rem_in    = '0;
            divcnt_in = '0;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_t0_in    = t0_ff;
               rsp_t1_in    = t1_ff;
               rsp_cost_in  = cost_big ? COST_MAX : div_ff[COST_W-1:0];
               rsp_count_in = COUNT_OUT_W'(count_ff);
               rsp_sat_in   = clip_ff || cost_big;
               count_in     = '0;
            end
         end
         default: begin
         end
      endcase

      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= LEARNING_RATE_RESET;
         iter_ff      <= ITERATION_COUNT_RESET;
         init_t0_ff   <= '0;
         init_t1_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         lr_ff        <= lr_in;
         iter_ff      <= iter_in;
         init_t0_ff   <= init_t0_in;
         init_t1_ff   <= init_t1_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pass_ff       <= pass_in;
      cost_phase_ff <= cost_phase_in;
      t0_ff         <= t0_in;
      t1_ff         <= t1_in;
      h_ff          <= h_in;
      c_ff          <= c_in;
      isum_ff       <= isum_in;
      ssum_ff       <= ssum_in;
      hx_ff         <= hx_in;
      csum_ff       <= csum_in;
      lo_ff         <= lo_in;
      prod_ff       <= prod_in;
      full_ff       <= full_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      divcnt_ff     <= divcnt_in;
      clip_ff       <= clip_in;
      rsp_t0_ff     <= rsp_t0_in;
      rsp_t1_ff     <= rsp_t1_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   // sample store: x in the upper half, y in the lower half
   always_ff @(posedge clock) begin
      if (mem_we) mem[count_ff[AW-1:0]] <= {req_sample_x, req_sample_y};
      rd_ff <= mem[idx_ff];
   end

   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fitted_intercept = rsp_t0_ff;
   assign rsp_fitted_slope     = rsp_t1_ff;
   assign rsp_final_cost       = rsp_cost_ff;
   assign rsp_sample_count     = rsp_count_ff;
   assign rsp_saturated        = rsp_sat_ff;

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_train_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (count_ff != '0))
      else $error("training with an empty sample set");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (CW'(idx_ff) < count_ff))
      else $error("sample index beyond the loaded count");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_sample) |=> (state_ff == ST_DIV))
      else $error("last sample did not start training");
`endif

endmodule

// File: verif/tb.sv
module tb;
   import lrgd_pkg::*;

   localparam int     SET_LIMIT      = 64;
   localparam int     Q_SHIFT        = 16;
   localparam longint Q_MAX          = 64'sd2147483647;
   localparam longint Q_MIN          = -64'sd2147483648;
   localparam longint ACC_TOP        = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_BOTTOM     = 64'sh8000_0000_0000_0000;
   localparam int     WATCHDOG_LIMIT = 3_000_000;
   localparam int     LONG_HOLD      = 3000;
   localparam int     RANDOM_PHASES  = 12;
   localparam int     PHASE_ITEMS    = 70;
   localparam int     PRINT_CAP      = 40;

   typedef struct packed {
      logic [DATA_W-1:0]      intercept;
      logic [DATA_W-1:0]      slope;
      logic [COST_W-1:0]      cost;
      logic [COUNT_OUT_W-1:0] count;
      logic                   sat;
   } line_fit_type;

   class fit_scoreboard;
      bit [LR_W-1:0]   step_size;
      bit [ITER_W-1:0] pass_total;
      longint          start_intercept;
      longint          start_slope;
      longint          x_mem[SET_LIMIT];
      longint          y_mem[SET_LIMIT];
      int unsigned     held;
      bit              clipped;
      line_fit_type    fits_due[$];
      int unsigned     mismatches;

      function new();
         step_size       = LEARNING_RATE_RESET;
         pass_total      = ITERATION_COUNT_RESET;
         start_intercept = 0;
         start_slope     = 0;
         held            = 0;
         clipped         = 1'b0;
         mismatches      = 0;
      endfunction

      function void note_config(logic [CSR_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
         case (idx)
            CSR_LEARNING_RATE:     step_size = data;
            CSR_ITERATION_COUNT:   pass_total = data[ITER_W-1:0];
            CSR_INITIAL_INTERCEPT: start_intercept = longint'($signed(data));
            CSR_INITIAL_SLOPE:     start_slope = longint'($signed(data));
            default: ;
         endcase
      endfunction

      function longint clip_q(longint v);
         if (v > Q_MAX) begin
            clipped = 1'b1;
            return Q_MAX;
         end
         if (v < Q_MIN) begin
            clipped = 1'b1;
            return Q_MIN;
         end
         return v;
      endfunction

      // floor(a * c / 2^sh) from the full 96 bit product, clipped to 64 bits
      function longint scaled_term(longint a, bit [31:0] c, int sh);
         logic signed [127:0] wide_a;
         logic signed [127:0] wide_c;
         logic signed [127:0] product;
         wide_a  = 128'(a);
         wide_c  = {96'd0, c};
         product = (wide_a * wide_c) >>> sh;
         if (product[127:63] != {65{product[127]}}) begin
            clipped = 1'b1;
            return product[127] ? ACC_BOTTOM : ACC_TOP;
         end
         return product[63:0];
      endfunction

      function longint acc_add(longint a, longint b);
         if (b > 0 && a > ACC_TOP - b) begin
            clipped = 1'b1;
            return ACC_TOP;
         end
         if (b < 0 && a < ACC_BOTTOM - b) begin
            clipped = 1'b1;
            return ACC_BOTTOM;
         end
         return a + b;
      endfunction

      function longint residual_at(int unsigned i, longint t0, longint t1);
         return clip_q(t0 + ((t1 * x_mem[i]) >>> Q_SHIFT) - y_mem[i]);
      endfunction

      function void note_sample(logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y,
                                logic last);
         int unsigned  n;
         int unsigned  i;
         int unsigned  pass_idx;
         bit [31:0]    rate;
         longint       t0;
         longint       t1;
         longint       isum;
         longint       ssum;
         longint       h;
         bit [63:0]    csum;
         bit [63:0]    sq;
         bit [63:0]    cost;
         line_fit_type fit;
         // drop samples once the store is full
         if (held < SET_LIMIT) begin
            x_mem[held] = longint'(x);
            y_mem[held] = longint'(y);
            held++;
         end
         if (!last)
            return;
         n       = held;
         rate    = step_size / n;
         clipped = 1'b0;
         t0      = start_intercept;
         t1      = start_slope;
         for (pass_idx = 0; pass_idx < pass_total; pass_idx++) begin
            isum = 0;
            ssum = 0;
            for (i = 0; i < n; i++) begin
               h    = residual_at(i, t0, t1);
               isum = acc_add(isum, scaled_term(h, rate, Q_SHIFT));
               ssum = acc_add(ssum, scaled_term(h * x_mem[i], rate, 2 * Q_SHIFT));
            end
            t0 = clip_q(t0 - (isum >>> (32 - Q_SHIFT)));
            t1 = clip_q(t1 - (ssum >>> (32 - Q_SHIFT)));
         end
         csum = 0;
         for (i = 0; i < n; i++) begin
            h  = residual_at(i, t0, t1);
            sq = h * h;
            sq = sq >> Q_SHIFT;
            if (csum > UINT64_MAX - sq) begin
               clipped = 1'b1;
               csum    = UINT64_MAX;
            end else begin
               csum = csum + sq;
            end
         end
         cost = csum / (64'd2 * n);
         if (cost > 64'(COST_MAX)) begin
            clipped = 1'b1;
            cost    = 64'(COST_MAX);
         end
         fit.intercept = t0[DATA_W-1:0];
         fit.slope     = t1[DATA_W-1:0];
         fit.cost      = cost[COST_W-1:0];
         fit.count     = n[COUNT_OUT_W-1:0];
         fit.sat       = clipped;
         fits_due.push_back(fit);
         held = 0;
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_CAP)
            $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_fit(line_fit_type got);
         line_fit_type want;
         if (fits_due.size() == 0) begin
            report_mismatch($sformatf("unexpected fit transaction %h", got));
            return;
         end
         want = fits_due.pop_front();
         if (got.intercept !== want.intercept)
            report_mismatch($sformatf("intercept got %h expected %h",
                                      got.intercept, want.intercept));
         if (got.slope !== want.slope)
            report_mismatch($sformatf("slope got %h expected %h", got.slope, want.slope));
         if (got.cost !== want.cost)
            report_mismatch($sformatf("cost got %h expected %h", got.cost, want.cost));
         if (got.count !== want.count)
            report_mismatch($sformatf("sample count got %0d expected %0d",
                                      got.count, want.count));
         if (got.sat !== want.sat)
            report_mismatch($sformatf("saturated got %b expected %b", got.sat, want.sat));
      endtask

      function int unsigned pending();
         return fits_due.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [DATA_W-1:0]      req_sample_x;
   logic signed [DATA_W-1:0]      req_sample_y;
   logic                          req_last_sample;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [DATA_W-1:0]      rsp_fitted_intercept;
   logic signed [DATA_W-1:0]      rsp_fitted_slope;
   logic        [COST_W-1:0]      rsp_final_cost;
   logic        [COUNT_OUT_W-1:0] rsp_sample_count;
   logic                          rsp_saturated;
   logic                          csr_valid;
   logic                          csr_ready;
   logic        [CSR_INDEX_W-1:0] csr_index;
   logic        [DATA_W-1:0]      csr_data;

   fit_scoreboard sb;
   bit            steady_flow;
   int            rsp_hold_cycles;

   linear_regression_gradient_descent_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sample_x         (req_sample_x),
      .req_sample_y         (req_sample_y),
      .req_last_sample      (req_last_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_fitted_intercept (rsp_fitted_intercept),
      .rsp_fitted_slope     (rsp_fitted_slope),
      .rsp_final_cost       (rsp_final_cost),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_saturated        (rsp_saturated),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [DATA_W-1:0] pick_q_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r < 35)
         return $urandom;
      if (r < 70)
         return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
      return 32'($urandom_range(0, 32'h1FF_FFFF)) - 32'h100_0000;
   endfunction

   function automatic logic [DATA_W-1:0] pick_rate();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 32'h0000_0000;
      if (r < 20)
         return 32'hFFFF_FFFF;
      if (r < 60)
         return $urandom_range(0, 200000);
      if (r < 80)
         return $urandom_range(0, 32'hFF_FFFF);
      return $urandom;
   endfunction

   // upper half of the word carries junk that the register must ignore
   function automatic logic [DATA_W-1:0] pick_passes(bit quick);
      int r;
      logic [ITER_W-1:0] passes;
      r = $urandom_range(0, 99);
      if (quick || (r >= 15 && r < 85))
         passes = ITER_W'($urandom_range(1, 4));
      else if (r < 15)
         passes = '0;
      else
         passes = ITER_W'(20);
      return {16'($urandom), passes};
   endfunction

   function automatic int pick_set_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 6);
      if (r < 85)
         return $urandom_range(7, 20);
      if (r < 93)
         return $urandom_range(21, 63);
      if (r < 96)
         return SET_LIMIT;
      return $urandom_range(SET_LIMIT + 1, SET_LIMIT + 6);
   endfunction

   task automatic send_sample(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic last);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_x    <= x;
      req_sample_y    <= y;
      req_last_sample <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(x, y, last);
   endtask

   // line-like sets hold small points scattered around a random line
   task automatic send_set(int len, bit line_like);
      longint            a_q;
      longint            b_q;
      longint            xv;
      longint            yv;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      int                k;
      a_q = longint'($urandom_range(0, 1048576)) - 64'sd524288;
      b_q = longint'($urandom_range(0, 524288)) - 64'sd262144;
      for (k = 0; k < len; k++) begin
         if (line_like) begin
            xv = longint'($urandom_range(0, 2097152)) - 64'sd1048576;
            yv = a_q + ((b_q * xv) >>> Q_SHIFT) + longint'($urandom_range(0, 4096)) - 64'sd2048;
            x  = xv[DATA_W-1:0];
            y  = yv[DATA_W-1:0];
         end else begin
            x = pick_q_value();
            y = pick_q_value();
         end
         send_sample(x, y, k == len - 1);
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.note_config(idx, data);
   endtask

   task automatic close_reg_writes();
      csr_valid <= 1'b0;
   endtask

   // hold the sender until every fit has come back, then let the block settle
   task automatic wait_for_fits();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic configure_phase(bit quick);
      if ($urandom_range(0, 9) < 7)
         write_reg(CSR_LEARNING_RATE, pick_rate());
      if (quick || $urandom_range(0, 9) < 7)
         write_reg(CSR_ITERATION_COUNT, pick_passes(quick));
      if ($urandom_range(0, 9) < 7)
         write_reg(CSR_INITIAL_INTERCEPT, pick_q_value());
      if ($urandom_range(0, 9) < 7)
         write_reg(CSR_INITIAL_SLOPE, pick_q_value());
      close_reg_writes();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_fit(line_fit_type'{rsp_fitted_intercept, rsp_fitted_slope, rsp_final_cost,
                                     rsp_sample_count, rsp_saturated});
   end

   initial begin : receiver
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("FAIL linear_regression_gradient_descent_core");
      $finish;
   end

   initial begin
      int phase;
      int items;
      int len;
      sb              = new();
      steady_flow     = 1'b0;
      rsp_hold_cycles = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_sample_x    <= '0;
      req_sample_y    <= '0;
      req_last_sample <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_LEARNING_RATE;
      csr_data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset
      send_sample(32'h0001_0000, 32'h0002_0000, 1'b0);
      send_sample(32'h0002_0000, 32'h0004_0000, 1'b1);
      wait_for_fits();

      // zero passes: emit the starting line and its cost
      write_reg(CSR_LEARNING_RATE, 32'h0000_0000);
      write_reg(CSR_ITERATION_COUNT, 32'h0000_0000);
      write_reg(CSR_INITIAL_INTERCEPT, 32'h7FFF_FFFF);
      write_reg(CSR_INITIAL_SLOPE, 32'h8000_0000);
      close_reg_writes();
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      wait_for_fits();

      // largest step size drives the parameters into their limits
      write_reg(CSR_LEARNING_RATE, 32'hFFFF_FFFF);
      write_reg(CSR_ITERATION_COUNT, 32'h0000_0003);
      write_reg(CSR_INITIAL_INTERCEPT, 32'h0000_0000);
      write_reg(CSR_INITIAL_SLOPE, 32'h0000_0000);
      close_reg_writes();
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_sample(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_sample(32'h0001_0000, 32'h8000_0000, 1'b1);
      wait_for_fits();

      // full pass count on a single sample
      write_reg(CSR_LEARNING_RATE, LEARNING_RATE_RESET);
      write_reg(CSR_ITERATION_COUNT, 32'hFFFF_FFFF);
      write_reg(CSR_INITIAL_INTERCEPT, 32'h0001_0000);
      write_reg(CSR_INITIAL_SLOPE, 32'hFFFF_0000);
      close_reg_writes();
      send_sample(32'h0003_0000, 32'h0001_0000, 1'b1);
      wait_for_fits();

      write_reg(CSR_LEARNING_RATE, 32'h8000_0000);
      write_reg(CSR_ITERATION_COUNT, 32'h0000_0001);
      write_reg(CSR_INITIAL_INTERCEPT, 32'hFFFF_FFFF);
      write_reg(CSR_INITIAL_SLOPE, 32'h0000_8000);
      close_reg_writes();
      send_set(5, 1'b1);
      wait_for_fits();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure_phase(phase == 2);
         steady_flow = ($urandom_range(0, 3) == 0);
         // stall the receiver long enough for the block to back up into its input
         if (phase == 2) begin
            steady_flow     = 1'b0;
            rsp_hold_cycles = LONG_HOLD;
         end
         if (phase == 0)
            send_set(SET_LIMIT + 3, 1'b0);
         items = 0;
         while (items < PHASE_ITEMS) begin
            len = pick_set_len();
            send_set(len, $urandom_range(0, 1));
            items += len;
         end
         wait_for_fits();
      end

      repeat (200) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d fits never arrived", sb.pending()));
      if (sb.mismatches == 0)
         $display("PASS linear_regression_gradient_descent_core");
      else
         $display("FAIL linear_regression_gradient_descent_core");
      $finish;
   end

endmodule
